>>> src/utf8_to_ascii_transliterator_assert.svh
// Assertion macros for the transliterator checker.
`ifndef UTF8_TO_ASCII_TRANSLITERATOR_ASSERT_SVH
`define UTF8_TO_ASCII_TRANSLITERATOR_ASSERT_SVH

// Same-cycle implication, off while reset is low.
`define UTA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is low.
`define UTA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Check of what reset leaves behind.
`define UTA_ASSERT_RESET(label, clk, rst_n, cons, msg) \
    label: assert property (@(posedge clk) (!rst_n) |=> (cons)) else $error(msg);

`endif

>>> src/uta_pkg.sv
// Types and constants of the UTF-8 to ASCII transliterator.
`timescale 1ns / 1ps
`default_nettype none
package uta_pkg;

    localparam int IN_TDATA_W   = 32;
    localparam int IN_TUSER_W   = 2;
    localparam int OUT_TDATA_W  = 24;
    localparam int OUT_TUSER_W  = 3;
    localparam int OUT_SPACE_W  = 16;
    localparam int CHAR_W       = 7;
    localparam int CP_W         = 21;
    localparam int MAX_RESULTS  = 8;
    localparam int RES_CNT_W    = 4;
    localparam int RES_IDX_W    = 3;
    localparam int MAP_BASE     = 'h0C0;

    localparam logic [CHAR_W-1:0] CH_SPACE = 7'h20;
    localparam logic [CHAR_W-1:0] CH_TAB   = 7'h09;
    localparam logic [CHAR_W-1:0] CASE_BIT = 7'h20;

    localparam logic [CHAR_W-1:0] UNTITLED_TEXT [MAX_RESULTS] =
        '{7'h55, 7'h6E, 7'h74, 7'h69, 7'h74, 7'h6C, 7'h65, 7'h64};

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_DATA  = 2'd1,
        CMD_END   = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK  = 2'd0,
        ST_BAD = 2'd1,
        ST_SAT = 2'd2
    } status_t;

    // Allowed range of the first continuation byte.
    typedef enum logic [2:0] {
        LIM_ANY = 3'd0,
        LIM_E0  = 3'd1,
        LIM_ED  = 3'd2,
        LIM_F0  = 3'd3,
        LIM_F4  = 3'd4
    } lim_t;

    // What the decode stage hands to the character stage.
    typedef enum logic [1:0] {
        OP_NONE = 2'd0,
        OP_CHAR = 2'd1,
        OP_MAP  = 2'd2,
        OP_END  = 2'd3
    } op_t;

    typedef struct packed {
        logic [OUT_SPACE_W-1:0] spaces;
        logic [CHAR_W-1:0]      ch;
        logic                   valid;
        logic                   last;
        status_t                status;
    } rslt_t;

    function automatic logic is_upper(input logic [CHAR_W-1:0] c);
        return (c >= 7'h41) && (c < 7'h5B);
    endfunction

    function automatic logic is_kept(input logic [CHAR_W-1:0] c);
        return ((c >= 7'h30) && (c <= 7'h39)) || is_upper(c) ||
               ((c >= 7'h61) && (c < 7'h7B)) || (c == CH_SPACE);
    endfunction

endpackage
`default_nettype wire

>>> src/uta_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module uta_ram #(
    parameter int WIDTH = 14,
    parameter int DEPTH = 192
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule
`default_nettype wire

>>> src/utf8_to_ascii_transliterator.sv
// Top level of the UTF-8 to ASCII transliterator.
// A request passes the request, decoded and result burst registers before its first result
// shows on m_tvalid. One request per cycle while each request gives at most one result and
// m_tready is high; a request with k results holds the result burst register until all k
// are taken (an empty string's end gives 8). Decode and table read are registered for assembly.
// Reset (aresetn low, synchronous) clears string and handshake state; the table is not.
`timescale 1ns / 1ps
`default_nettype none
module utf8_to_ascii_transliterator #(
    parameter int TABLE_DEPTH      = 192,
    parameter int SPACE_COUNT_BITS = 16
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output      logic                           s_tready,
    // data_byte[7:0], entry_index[15:8], entry_first[22:16], entry_second[29:23], zero pad
    input  wire logic [uta_pkg::IN_TDATA_W-1:0] s_tdata,
    // command[1:0]
    input  wire logic [uta_pkg::IN_TUSER_W-1:0] s_tuser,
    output      logic                           m_tvalid,
    input  wire logic                           m_tready,
    // spaces_before[15:0], out_char[22:16], zero pad
    output      logic [uta_pkg::OUT_TDATA_W-1:0] m_tdata,
    // char_valid[0], status[2:1]
    output      logic [uta_pkg::OUT_TUSER_W-1:0] m_tuser,
    output      logic                            m_tlast
);
    import uta_pkg::*;

    // Space runs never exceed what the 16-bit result field can carry.
    localparam int CNT_W  = (SPACE_COUNT_BITS < OUT_SPACE_W) ? SPACE_COUNT_BITS : OUT_SPACE_W;
    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam logic [CNT_W-1:0] SPACE_CAP = {CNT_W{1'b1}};
    localparam logic [CP_W-1:0]  MAP_LO    = CP_W'(MAP_BASE);
    localparam logic [CP_W-1:0]  MAP_HI    = CP_W'(MAP_BASE + TABLE_DEPTH);
    localparam logic [8:0]       IDX_LIMIT = 9'(TABLE_DEPTH);

    typedef struct packed {
        logic [CHAR_W-1:0] held;
        logic [CNT_W-1:0]  pend;
        logic              seen;
    } cs_t;

    typedef struct packed {
        cs_t   st;
        logic  r0_v;
        rslt_t r0;
        logic  r1_v;
        rslt_t r1;
    } push_t;

    // ---------------------------------------------------------------
    // Handshake chain: request register (A), decoded register (B),
    // result burst register (C). Each stage moves when the next frees.
    // ---------------------------------------------------------------
    logic a_valid_reg, b_valid_reg;
    logic [RES_CNT_W-1:0] c_cnt_reg;
    logic [RES_IDX_W-1:0] c_idx_reg;
    logic c_free, b_ready, b_adv, a_ready, a_adv;

    assign c_free   = (c_cnt_reg == '0) || ((c_cnt_reg == RES_CNT_W'(1)) && m_tready);
    assign b_ready  = !b_valid_reg || c_free;
    assign b_adv    = b_valid_reg && c_free;
    assign a_ready  = !a_valid_reg || b_ready;
    assign a_adv    = a_valid_reg && b_ready;
    assign s_tready = a_ready;

    // Request register payload.
    cmd_t              a_cmd_reg;
    logic [7:0]        a_data_reg;
    logic [7:0]        a_idx_reg;
    logic [CHAR_W-1:0] a_first_reg;
    logic [CHAR_W-1:0] a_second_reg;

    // ---------------------------------------------------------------
    // Stage A: strict UTF-8 decode and table address.
    // ---------------------------------------------------------------
    logic [CP_W-1:0] cp_reg, cp_next;
    logic [1:0]      rem_reg, rem_next;
    lim_t            lim_reg, lim_next;
    logic            err_reg, err_next;
    logic            nonempty_reg, nonempty_next;

    op_t               dec_op;
    logic [CHAR_W-1:0] dec_char;
    logic              dec_err, dec_empty;
    logic [ADDR_W-1:0] dec_addr;

    always_comb begin
        logic            bad;
        logic            done;
        logic [CP_W-1:0] cp_val;
        logic [CP_W-1:0] cp_acc;
        logic [CP_W-1:0] map_off;
        logic [7:0]      lo;
        logic [7:0]      hi;

        cp_next       = cp_reg;
        rem_next      = rem_reg;
        lim_next      = lim_reg;
        err_next      = err_reg;
        nonempty_next = nonempty_reg;
        dec_op        = OP_NONE;
        dec_char      = '0;
        dec_err       = 1'b0;
        dec_empty     = 1'b0;
        dec_addr      = '0;
        bad           = 1'b0;
        done          = 1'b0;
        cp_val        = '0;
        cp_acc        = {cp_reg[CP_W-7:0], a_data_reg[5:0]};
        map_off       = '0;
        lo            = 8'h80;
        hi            = 8'hBF;

        case (a_cmd_reg)
            CMD_DATA: begin
                nonempty_next = 1'b1;
                if (!err_reg) begin
                    if (rem_reg == 2'd0) begin
                        if (a_data_reg < 8'h80) begin
                            if (a_data_reg == 8'h00) begin
                                bad = 1'b1;
                            end else begin
                                done   = 1'b1;
                                cp_val = CP_W'(a_data_reg);
                            end
                        end else if (a_data_reg < 8'hC2) begin
                            bad = 1'b1;
                        end else if (a_data_reg < 8'hE0) begin
                            cp_next  = CP_W'(a_data_reg[4:0]);
                            rem_next = 2'd1;
                            lim_next = LIM_ANY;
                        end else if (a_data_reg < 8'hF0) begin
                            cp_next  = CP_W'(a_data_reg[3:0]);
                            rem_next = 2'd2;
                            lim_next = (a_data_reg == 8'hE0) ? LIM_E0 :
                                       (a_data_reg == 8'hED) ? LIM_ED : LIM_ANY;
                        end else if (a_data_reg < 8'hF5) begin
                            cp_next  = CP_W'(a_data_reg[2:0]);
                            rem_next = 2'd3;
                            lim_next = (a_data_reg == 8'hF0) ? LIM_F0 :
                                       (a_data_reg == 8'hF4) ? LIM_F4 : LIM_ANY;
                        end else begin
                            bad = 1'b1;
                        end
                    end else begin
                        unique case (lim_reg)
                            LIM_E0:  lo = 8'hA0;
                            LIM_ED:  hi = 8'h9F;
                            LIM_F0:  lo = 8'h90;
                            LIM_F4:  hi = 8'h8F;
                            default: ;
                        endcase
                        if ((a_data_reg < lo) || (a_data_reg > hi)) begin
                            bad = 1'b1;
                        end else begin
                            lim_next = LIM_ANY;
                            rem_next = rem_reg - 2'd1;
                            if (rem_reg == 2'd1) begin
                                done    = 1'b1;
                                cp_val  = cp_acc;
                                cp_next = '0;
                            end else begin
                                cp_next = cp_acc;
                            end
                        end
                    end
                    if (bad) begin
                        err_next = 1'b1;
                        cp_next  = '0;
                        rem_next = 2'd0;
                        lim_next = LIM_ANY;
                    end
                end
            end
            CMD_END: begin
                // A sequence cut short counts as bad input; then clear the string.
                dec_op        = OP_END;
                dec_err       = err_reg || (rem_reg != 2'd0);
                dec_empty     = !nonempty_reg;
                cp_next       = '0;
                rem_next      = 2'd0;
                lim_next      = LIM_ANY;
                err_next      = 1'b0;
                nonempty_next = 1'b0;
            end
            default: ;
        endcase

        // Classify a finished code point.
        map_off = cp_val - MAP_LO;
        if (done) begin
            if ((cp_val < CP_W'(8'h80)) && is_kept(cp_val[CHAR_W-1:0])) begin
                dec_op   = OP_CHAR;
                dec_char = cp_val[CHAR_W-1:0];
            end else if (cp_val == CP_W'(CH_TAB)) begin
                dec_op   = OP_CHAR;
                dec_char = CH_SPACE;
            end else if ((cp_val >= MAP_LO) && (cp_val < MAP_HI)) begin
                dec_op   = OP_MAP;
                dec_addr = map_off[ADDR_W-1:0];
            end
        end
    end

    // Mapping table: written from stage A, read into stage B.
    logic              tbl_we;
    logic [2*CHAR_W-1:0] map_rdata;

    assign tbl_we = a_adv && (a_cmd_reg == CMD_WRITE) && ({1'b0, a_idx_reg} < IDX_LIMIT);

    uta_ram #(
        .WIDTH (2 * CHAR_W),
        .DEPTH (TABLE_DEPTH)
    ) u_map_ram (
        .clk   (aclk),
        .we    (tbl_we),
        .waddr (a_idx_reg[ADDR_W-1:0]),
        .wdata ({a_second_reg, a_first_reg}),
        .re    (a_adv),
        .raddr (dec_addr),
        .rdata (map_rdata)
    );

    // ---------------------------------------------------------------
    // Stage B: held letter, space runs and result assembly.
    // ---------------------------------------------------------------
    op_t               b_op_reg;
    logic [CHAR_W-1:0] b_char_reg;
    logic              b_err_reg;
    logic              b_empty_reg;

    logic [CHAR_W-1:0] held_reg, held_next;
    logic [CNT_W-1:0]  pend_reg, pend_next;
    logic              seen_reg, seen_next;

    rslt_t                res_slot [MAX_RESULTS];
    logic [RES_CNT_W-1:0] res_cnt;

    // A character result carries the pending space run before it.
    function automatic rslt_t mk_emit(input logic [CHAR_W-1:0] c, input logic [CNT_W-1:0] pend,
                                      input logic last);
        rslt_t r;
        r.spaces = OUT_SPACE_W'(pend);
        r.ch     = c;
        r.valid  = 1'b1;
        r.last   = last;
        r.status = (pend == SPACE_CAP) ? ST_SAT : ST_OK;
        return r;
    endfunction

    // Resolve any held letter against c, then count or send c.
    function automatic push_t push_char(input cs_t st, input logic [CHAR_W-1:0] c);
        push_t p;
        p    = '0;
        p.st = st;
        if (st.held != '0) begin
            p.r0_v    = 1'b1;
            p.r0      = mk_emit(is_upper(c) ? st.held : (st.held | CASE_BIT), st.pend, 1'b0);
            p.st.held = '0;
            p.st.pend = '0;
            p.st.seen = 1'b1;
        end
        if (c == CH_SPACE) begin
            if (p.st.seen && (p.st.pend != SPACE_CAP)) begin
                p.st.pend = p.st.pend + CNT_W'(1);
            end
        end else begin
            p.r1_v    = 1'b1;
            p.r1      = mk_emit(c, p.st.pend, 1'b0);
            p.st.pend = '0;
            p.st.seen = 1'b1;
        end
        return p;
    endfunction

    always_comb begin
        cs_t               st;
        push_t             p;
        logic [CHAR_W-1:0] f;
        logic [CHAR_W-1:0] s;

        st      = '{held: held_reg, pend: pend_reg, seen: seen_reg};
        p       = '0;
        f       = map_rdata[CHAR_W-1:0];
        s       = map_rdata[2*CHAR_W-1:CHAR_W];
        res_cnt = '0;
        for (int k = 0; k < MAX_RESULTS; k++) begin
            res_slot[k] = '0;
        end

        case (b_op_reg)
            OP_CHAR: begin
                p  = push_char(st, b_char_reg);
                st = p.st;
                if (p.r0_v) begin
                    res_slot[res_cnt[RES_IDX_W-1:0]] = p.r0;
                    res_cnt = res_cnt + RES_CNT_W'(1);
                end
                if (p.r1_v) begin
                    res_slot[res_cnt[RES_IDX_W-1:0]] = p.r1;
                    res_cnt = res_cnt + RES_CNT_W'(1);
                end
            end
            OP_MAP: begin
                if (f != '0) begin
                    p  = push_char(st, f);
                    st = p.st;
                    if (p.r0_v) begin
                        res_slot[res_cnt[RES_IDX_W-1:0]] = p.r0;
                        res_cnt = res_cnt + RES_CNT_W'(1);
                    end
                    if (p.r1_v) begin
                        res_slot[res_cnt[RES_IDX_W-1:0]] = p.r1;
                        res_cnt = res_cnt + RES_CNT_W'(1);
                    end
                    if (s != '0) begin
                        if (is_upper(s)) begin
                            // Nothing is held after the first character; hold this one.
                            st.held = s;
                            st.seen = 1'b1;
                        end else begin
                            p  = push_char(st, s);
                            st = p.st;
                            if (p.r0_v) begin
                                res_slot[res_cnt[RES_IDX_W-1:0]] = p.r0;
                                res_cnt = res_cnt + RES_CNT_W'(1);
                            end
                            if (p.r1_v) begin
                                res_slot[res_cnt[RES_IDX_W-1:0]] = p.r1;
                                res_cnt = res_cnt + RES_CNT_W'(1);
                            end
                        end
                    end
                end
            end
            OP_END: begin
                res_cnt = RES_CNT_W'(1);
                if (b_err_reg) begin
                    res_slot[0] = '{spaces: '0, ch: '0, valid: 1'b0, last: 1'b1,
                                    status: ST_BAD};
                end else if (b_empty_reg) begin
                    res_cnt = RES_CNT_W'(MAX_RESULTS);
                    for (int k = 0; k < MAX_RESULTS; k++) begin
                        res_slot[k] = '{spaces: '0, ch: UNTITLED_TEXT[k], valid: 1'b1,
                                        last: (k == MAX_RESULTS - 1), status: ST_OK};
                    end
                end else if (st.held != '0) begin
                    // A held letter with nothing after it stays uppercase.
                    res_slot[0] = mk_emit(st.held, st.pend, 1'b1);
                end else begin
                    res_slot[0] = '{spaces: '0, ch: '0, valid: 1'b0, last: 1'b1,
                                    status: ST_OK};
                end
                st = '0;
            end
            default: ;
        endcase

        held_next = st.held;
        pend_next = st.pend;
        seen_next = st.seen;
    end

    // ---------------------------------------------------------------
    // Stage C: result burst register, drained one result per cycle while m_tready is high.
    // ---------------------------------------------------------------
    rslt_t c_slot_reg [MAX_RESULTS];
    rslt_t cur;

    assign cur      = c_slot_reg[c_idx_reg];
    assign m_tvalid = (c_cnt_reg != '0);
    assign m_tdata  = {1'b0, cur.ch, cur.spaces};
    assign m_tuser  = {cur.status, cur.valid};
    assign m_tlast  = cur.last;

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg  <= 1'b0;
            b_valid_reg  <= 1'b0;
            c_cnt_reg    <= '0;
            c_idx_reg    <= '0;
            cp_reg       <= '0;
            rem_reg      <= 2'd0;
            lim_reg      <= LIM_ANY;
            err_reg      <= 1'b0;
            nonempty_reg <= 1'b0;
            held_reg     <= '0;
            pend_reg     <= '0;
            seen_reg     <= 1'b0;
        end else begin
            if (a_ready) begin
                a_valid_reg <= s_tvalid;
            end
            if (b_ready) begin
                b_valid_reg <= a_valid_reg;
            end
            if (a_adv) begin
                cp_reg       <= cp_next;
                rem_reg      <= rem_next;
                lim_reg      <= lim_next;
                err_reg      <= err_next;
                nonempty_reg <= nonempty_next;
            end
            if (b_adv) begin
                held_reg  <= held_next;
                pend_reg  <= pend_next;
                seen_reg  <= seen_next;
                c_cnt_reg <= res_cnt;
                c_idx_reg <= '0;
            end else if (m_tvalid && m_tready) begin
                c_cnt_reg <= c_cnt_reg - RES_CNT_W'(1);
                c_idx_reg <= c_idx_reg + RES_IDX_W'(1);
            end
        end
    end

    // Payload registers; hold while their stage stalls.
    always_ff @(posedge aclk) begin
        if (a_ready) begin
            a_cmd_reg    <= cmd_t'(s_tuser);
            a_data_reg   <= s_tdata[7:0];
            a_idx_reg    <= s_tdata[15:8];
            a_first_reg  <= s_tdata[22:16];
            a_second_reg <= s_tdata[29:23];
        end
        if (b_ready) begin
            b_op_reg    <= a_valid_reg ? dec_op : OP_NONE;
            b_char_reg  <= dec_char;
            b_err_reg   <= dec_err;
            b_empty_reg <= dec_empty;
        end
        if (b_adv) begin
            for (int k = 0; k < MAX_RESULTS; k++) begin
                c_slot_reg[k] <= res_slot[k];
            end
        end
    end

endmodule
`default_nettype wire

>>> src/uta_checker.sv
// Port-level checker of the transliterator result channel, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "utf8_to_ascii_transliterator_assert.svh"
module uta_checker (
    input wire logic                            aclk,
    input wire logic                            aresetn,
    input wire logic                            m_tvalid,
    input wire logic                            m_tready,
    input wire logic [uta_pkg::OUT_TDATA_W-1:0] m_tdata,
    input wire logic [uta_pkg::OUT_TUSER_W-1:0] m_tuser,
    input wire logic                            m_tlast
);
    import uta_pkg::*;

    `UTA_ASSERT_NEXT(a_hold_stalled, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled result changed")
    `UTA_ASSERT_RESET(a_reset_idle, aclk, aresetn, !m_tvalid, "result valid right after reset")
    `UTA_ASSERT_SAME(a_bad_is_final, aclk, aresetn, m_tvalid && (m_tuser[2:1] == ST_BAD), m_tlast && !m_tuser[0], "bad input result not a bare final result")
    `UTA_ASSERT_SAME(a_empty_is_last, aclk, aresetn, m_tvalid && !m_tuser[0], m_tlast && (m_tdata[15:0] == 16'd0), "result without character is not a bare last")

endmodule

bind utf8_to_ascii_transliterator uta_checker u_uta_checker (.*);
`default_nettype wire

>>> test/tb.sv
// Self-checking testbench for the UTF-8 to ASCII transliterator stream block.
`timescale 1ns / 1ps
`default_nettype none
module tb;
    import uta_pkg::*;

    // Block configuration under test and derived limits.
    localparam int TBL_DEPTH    = 192;
    localparam int SPACE_BITS   = 16;
    localparam int SPACE_CAP    = (SPACE_BITS >= 16) ? 65535 : (1 << SPACE_BITS) - 1;
    localparam int TABLE_BASE   = 'hC0;
    // Table entries loaded up front; lookups stay within them.
    localparam int LOADED_ENTRIES = 24;
    localparam int RANDOM_ITEMS = 105;
    // Quiet cycles tolerated before giving up. The slowest legal stretch is a
    // burst of 8 results, each held up by a receiver stall, plus a sender gap
    // and the pipeline registers.
    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 16;

    localparam logic [1:0]  CMD_UNUSED     = 2'd3;
    localparam logic [6:0]  SPACE_CHAR     = 7'h20;
    localparam logic [6:0]  TAB_CHAR       = 7'h09;
    localparam logic [63:0] FALLBACK_TITLE = "Untitled";

    logic                    aclk;
    logic                    aresetn  = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [IN_TDATA_W-1:0]   s_tdata  = '0;
    logic [IN_TUSER_W-1:0]   s_tuser  = '0;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]  m_tdata;
    logic [OUT_TUSER_W-1:0]  m_tuser;
    logic                    m_tlast;

    utf8_to_ascii_transliterator #(
        .TABLE_DEPTH     (TBL_DEPTH),
        .SPACE_COUNT_BITS(SPACE_BITS)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Transliteration state mirrored from the block
    // ------------------------------------------------------------------
    logic [13:0] xlat_table [TBL_DEPTH];   // {second, first}
    logic [20:0] cp_accum     = '0;
    int          cont_left    = 0;
    int          cont_lo      = 'h80;
    int          cont_hi      = 'hBF;
    logic [6:0]  held_capital = '0;
    int          space_run    = 0;
    bit          text_started = 1'b0;
    bit          got_bytes    = 1'b0;
    bit          locked       = 1'b0;

    rslt_t       predicted_chars [$];

    // Run statistics.
    int n_requests = 0;
    int n_results  = 0;
    int n_strings  = 0;
    int n_rejected = 0;
    int n_errors   = 0;

    // Sender burst control.
    int burst_left    = 0;

    function automatic bit is_capital(input int c);
        return c >= 'h41 && c < 'h5B;
    endfunction

    task automatic push_result(input int sp, input logic [6:0] ch, input bit valid,
                               input bit last, input status_t st);
        rslt_t r;
        r.spaces = sp[15:0];
        r.ch     = ch;
        r.valid  = valid;
        r.last   = last;
        r.status = st;
        predicted_chars = {predicted_chars, r};
    endtask

    // Flush the counted space run in front of a character.
    task automatic emit_char(input logic [6:0] ch, input bit last);
        push_result(space_run, ch, 1'b1, last, (space_run >= SPACE_CAP) ? ST_SAT : ST_OK);
        space_run    = 0;
        text_started = 1'b1;
    endtask

    // A held capital stays uppercase only when the next character is uppercase.
    task automatic settle_held(input logic [6:0] next_ch);
        logic [6:0] h;
        if (held_capital != 0) begin
            h            = held_capital;
            held_capital = '0;
            if (!is_capital(next_ch))
                h = h + 7'h20;
            emit_char(h, 1'b0);
        end
    endtask

    task automatic put_char(input logic [6:0] c);
        settle_held(c);
        if (c == SPACE_CHAR) begin
            // Leading spaces vanish; the run saturates at the cap.
            if (text_started && space_run < SPACE_CAP)
                space_run++;
        end else begin
            emit_char(c, 1'b0);
        end
    endtask

    task automatic handle_code_point(input logic [20:0] cp);
        logic [13:0] e;
        logic [6:0]  f;
        logic [6:0]  s;
        if ((cp >= 'h30 && cp <= 'h39) || cp == SPACE_CHAR || is_capital(cp) ||
            (cp >= 'h61 && cp < 'h7B)) begin
            put_char(cp[6:0]);
        end else if (cp == TAB_CHAR) begin
            put_char(SPACE_CHAR);
        end else if (cp >= TABLE_BASE && cp < TABLE_BASE + TBL_DEPTH) begin
            e = xlat_table[cp - TABLE_BASE];
            f = e[6:0];
            s = e[13:7];
            if (f != 0) begin
                put_char(f);
                if (s != 0) begin
                    if (is_capital(s)) begin
                        settle_held(s);
                        held_capital = s;
                        text_started = 1'b1;
                    end else begin
                        put_char(s);
                    end
                end
            end
        end
    endtask

    task automatic set_locked();
        locked    = 1'b1;
        cp_accum  = '0;
        cont_left = 0;
        cont_lo   = 'h80;
        cont_hi   = 'hBF;
    endtask

    task automatic decode_byte(input logic [7:0] b);
        if (cont_left == 0) begin
            if (b < 'h80) begin
                if (b == 0) set_locked();
                else handle_code_point(b);
            end else if (b < 'hC2) begin
                set_locked();
            end else if (b < 'hE0) begin
                cp_accum  = b[4:0];
                cont_left = 1;
            end else if (b < 'hF0) begin
                cp_accum  = b[3:0];
                cont_left = 2;
                // Narrow the first continuation: no overlongs, no surrogates.
                if (b == 'hE0) cont_lo = 'hA0;
                if (b == 'hED) cont_hi = 'h9F;
            end else if (b < 'hF5) begin
                cp_accum  = b[2:0];
                cont_left = 3;
                // No overlongs, nothing above the last plane.
                if (b == 'hF0) cont_lo = 'h90;
                if (b == 'hF4) cont_hi = 'h8F;
            end else begin
                set_locked();
            end
        end else if (b < cont_lo || b > cont_hi) begin
            set_locked();
        end else begin
            cp_accum = {cp_accum[14:0], b[5:0]};
            cont_lo  = 'h80;
            cont_hi  = 'hBF;
            cont_left--;
            if (cont_left == 0) begin
                handle_code_point(cp_accum);
                cp_accum = '0;
            end
        end
    endtask

    // Work out the results of one accepted request.
    task automatic transliterate_request(input logic [1:0] cmd, input logic [31:0] payload);
        int         k;
        logic [7:0] t;
        logic [6:0] h;
        case (cmd)
            CMD_WRITE: begin
                if (payload[15:8] < TBL_DEPTH)
                    xlat_table[payload[15:8]] = payload[29:16];
            end
            CMD_DATA: begin
                got_bytes = 1'b1;
                if (!locked)
                    decode_byte(payload[7:0]);
            end
            CMD_END: begin
                if (cont_left != 0)
                    set_locked();
                if (locked) begin
                    n_rejected++;
                    push_result(0, '0, 1'b0, 1'b1, ST_BAD);
                end else if (!got_bytes) begin
                    for (k = 0; k < 8; k++) begin
                        t = FALLBACK_TITLE[63 - 8 * k -: 8];
                        push_result(0, t[6:0], 1'b1, k == 7, ST_OK);
                    end
                end else if (held_capital != 0) begin
                    // Nothing follows, so the capital stays uppercase.
                    h            = held_capital;
                    held_capital = '0;
                    emit_char(h, 1'b1);
                end else begin
                    push_result(0, '0, 1'b0, 1'b1, ST_OK);
                end
                cp_accum     = '0;
                cont_left    = 0;
                cont_lo      = 'h80;
                cont_hi      = 'hBF;
                held_capital = '0;
                space_run    = 0;
                text_started = 1'b0;
                got_bytes    = 1'b0;
                locked       = 1'b0;
            end
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------
    function automatic logic [31:0] pack_request(input logic [7:0] b, input logic [7:0] idx,
                                                 input logic [6:0] f, input logic [6:0] s);
        return {2'b00, s, f, idx, b};
    endfunction

    // Drive one request, hold it until accepted, then maybe open a gap.
    task automatic send_request(input logic [1:0] cmd, input logic [31:0] payload);
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= payload;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        transliterate_request(cmd, payload);
        n_requests++;
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            // Mostly short bursts, now and then a long gap-free stretch.
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(0, 12);
        end else begin
            burst_left--;
        end
    endtask

    // Unused fields of data and end requests carry noise.
    task automatic send_byte(input logic [7:0] b);
        send_request(CMD_DATA, pack_request(b, $urandom_range(0, 255),
                                            $urandom_range(0, 127), $urandom_range(0, 127)));
    endtask

    task automatic send_end();
        send_request(CMD_END, pack_request($urandom_range(0, 255), $urandom_range(0, 255),
                                           $urandom_range(0, 127), $urandom_range(0, 127)));
        n_strings++;
    endtask

    task automatic write_entry(input logic [7:0] idx, input logic [6:0] f, input logic [6:0] s);
        send_request(CMD_WRITE, pack_request($urandom_range(0, 255), idx, f, s));
    endtask

    task automatic send_text(input string txt);
        int i;
        for (i = 0; i < txt.len(); i++)
            send_byte(txt[i]);
    endtask

    task automatic send_code_point(input int cp);
        logic [20:0] v;
        v = cp;
        if (cp < 'h80) begin
            send_byte(v[7:0]);
        end else if (cp < 'h800) begin
            send_byte({3'b110, v[10:6]});
            send_byte({2'b10, v[5:0]});
        end else if (cp < 'h10000) begin
            send_byte({4'b1110, v[15:12]});
            send_byte({2'b10, v[11:6]});
            send_byte({2'b10, v[5:0]});
        end else begin
            send_byte({5'b11110, v[20:18]});
            send_byte({2'b10, v[17:12]});
            send_byte({2'b10, v[11:6]});
            send_byte({2'b10, v[5:0]});
        end
    endtask

    // Drop valid and hold off until every predicted result has come out.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (predicted_chars.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [6:0] random_map_char();
        case ($urandom_range(0, 5))
            0:       return 7'h00;
            1:       return 7'h41 + $urandom_range(0, 25);
            2:       return 7'h61 + $urandom_range(0, 25);
            3:       return SPACE_CHAR;
            default: return $urandom_range(1, 127);
        endcase
    endfunction

    function automatic logic [6:0] random_plain_char();
        case ($urandom_range(0, 3))
            0:       return 7'h41 + $urandom_range(0, 25);
            1:       return 7'h61 + $urandom_range(0, 25);
            2:       return 7'h30 + $urandom_range(0, 9);
            default: return SPACE_CHAR;
        endcase
    endfunction

    // One kind of broken UTF-8; flag a sequence that the string end cuts short.
    task automatic send_malformed(output bit cut);
        cut = 1'b0;
        case ($urandom_range(0, 9))
            0: send_byte(8'h00);
            1: send_byte($urandom_range('h80, 'hBF));
            2: begin
                send_byte($urandom_range('hC0, 'hC1));
                send_byte($urandom_range('h80, 'hBF));
            end
            3: send_byte($urandom_range('hF5, 'hFF));
            4: begin
                send_byte(8'hE0);
                send_byte($urandom_range('h80, 'h9F));
            end
            5: begin
                send_byte(8'hF0);
                send_byte($urandom_range('h80, 'h8F));
            end
            6: begin
                send_byte(8'hED);
                send_byte($urandom_range('hA0, 'hBF));
            end
            7: begin
                send_byte(8'hF4);
                send_byte($urandom_range('h90, 'hBF));
            end
            8: begin
                // Lead byte followed by something that is no continuation.
                send_byte($urandom_range('hC2, 'hF4));
                send_byte($urandom_range(0, 1) ? $urandom_range(1, 'h7F)
                                               : $urandom_range('hC0, 'hFF));
            end
            default: begin
                send_byte($urandom_range('hE1, 'hEC));
                if ($urandom_range(0, 1)) send_byte($urandom_range('h80, 'hBF));
                cut = 1'b1;
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Fill the low table entries; every lookup stays within them.
    task automatic load_table();
        int i;
        for (i = 0; i < LOADED_ENTRIES; i++) begin
            if (i == 'hC6 - TABLE_BASE) write_entry(i, "A", "E");
            else write_entry(i, random_map_char(), random_map_char());
        end
    endtask

    task automatic test_empty_string();
        send_end();
    endtask

    // Leading space dropped, tab counted as space, trailing spaces never sent.
    task automatic test_spacing();
        send_text(" a\t 9Z  ");
        send_end();
    endtask

    // Held capital: lowercased before a lowercase letter, uppercase at the end.
    task automatic test_held_capital();
        send_code_point('hC6);
        send_text("x");
        send_code_point('hC6);
        send_end();
    endtask

    task automatic test_bad_utf8();
        // Surrogate, then a continuation that the lock must swallow.
        send_byte(8'hED);
        send_byte(8'hA0);
        send_byte(8'h80);
        send_end();
        // Forbidden lead byte in the middle of text.
        send_text("a");
        send_byte(8'hC0);
        send_text("b");
        send_end();
        // Sequence cut short by the end of the string.
        send_byte(8'hE2);
        send_byte(8'h82);
        send_end();
    endtask

    // Out-of-range table write and the unused command must change nothing.
    task automatic test_ignored_requests();
        write_entry(TBL_DEPTH + ('hC6 - TABLE_BASE), "Q", "0");
        send_request(CMD_UNUSED, $urandom);
        send_code_point('hC6);
        send_end();
    endtask

    task automatic test_random_strings();
        int target;
        int len;
        int u;
        int cp;
        bit cut;
        target = n_requests + RANDOM_ITEMS;
        while (n_requests < target) begin
            len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 14);
            cut = 1'b0;
            for (u = 0; u < len && !cut; u++) begin
                case ($urandom_range(0, 19))
                    0, 1, 2, 3: send_byte(random_plain_char());
                    4:          send_byte(TAB_CHAR);
                    5:          send_byte(SPACE_CHAR);
                    6:          send_byte($urandom_range(1, 127));
                    7, 8, 9:    send_code_point(TABLE_BASE +
                                                $urandom_range(0, LOADED_ENTRIES - 1));
                    // Two-byte code points outside the table range.
                    10:         send_code_point($urandom_range(0, 1) ?
                                                $urandom_range('h80, TABLE_BASE - 1) :
                                                $urandom_range(TABLE_BASE + TBL_DEPTH,
                                                               'h7FF));
                    11: begin
                        cp = $urandom_range('h800, 'hFFFF);
                        if (cp >= 'hD800 && cp <= 'hDFFF) cp = cp - 'h800;
                        send_code_point(cp);
                    end
                    12:         send_code_point($urandom_range('h10000, 'h10FFFF));
                    13:         write_entry($urandom_range(0, 255), random_map_char(),
                                            random_map_char());
                    14:         send_request(CMD_UNUSED, $urandom);
                    15:         send_byte(7'h41 + $urandom_range(0, 25));
                    default: begin
                        if ($urandom_range(0, 3) == 0) send_malformed(cut);
                        else send_byte(random_plain_char());
                    end
                endcase
            end
            send_end();
            // Let the pipeline run dry now and then, always after the tenth string.
            if (n_strings == 10 || $urandom_range(0, 7) == 0)
                drain_results();
        end
    endtask

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    // Receiver stalls: switch among always ready, coin toss, one in four and
    // mostly ready, each for a random stretch.
    int         stall_mode  = 0;
    logic [7:0] stall_phase = '0;

    always @(posedge aclk) begin
        if (stall_phase == 0) begin
            stall_mode  <= $urandom_range(0, 3);
            stall_phase <= $urandom_range(16, 96);
        end else begin
            stall_phase <= stall_phase - 1;
        end
        case (stall_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= $urandom_range(0, 1);
            2:       m_tready <= (stall_phase[1:0] == 2'b00);
            default: m_tready <= ($urandom_range(0, 7) != 0);
        endcase
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        n_errors++;
        if (n_errors <= 30)
            $display("ERROR at %0t ns, result %0d: %s is 0x%0h, want 0x%0h",
                     $time, n_results, what, got, want);
    endtask

    // Compare each delivered result with the oldest prediction.
    always @(posedge aclk) begin : check_char_results
        rslt_t want;
        if (aresetn && m_tvalid && m_tready) begin
            n_results++;
            if (predicted_chars.size() == 0) begin
                report_mismatch("result with none pending", m_tdata, 0);
            end else begin
                want = predicted_chars.pop_front();
                if (m_tdata[15:0] !== want.spaces)
                    report_mismatch("spaces_before", m_tdata[15:0], want.spaces);
                if (m_tdata[22:16] !== want.ch)
                    report_mismatch("out_char", m_tdata[22:16], want.ch);
                if (m_tuser[0] !== want.valid)
                    report_mismatch("char_valid", m_tuser[0], want.valid);
                if (m_tuser[2:1] !== want.status)
                    report_mismatch("status", m_tuser[2:1], want.status);
                if (m_tlast !== want.last)
                    report_mismatch("is_last", m_tlast, want.last);
            end
        end
    end

    // Watchdog: give up after a long stretch with no handshake on either side.
    int quiet_cycles = 0;

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == QUIET_LIMIT) begin
                $display("Watchdog: no request or result moved for %0d cycles, %0d pending",
                         QUIET_LIMIT, predicted_chars.size());
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        load_table();
        test_empty_string();
        test_spacing();
        test_held_capital();
        test_bad_utf8();
        test_ignored_requests();
        test_random_strings();

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (predicted_chars.size() != 0)
            report_mismatch("results never delivered", predicted_chars.size(), 0);

        $display("Run: %0d requests in %0d strings, %0d rejected as bad UTF-8, %0d results",
                 n_requests, n_strings, n_rejected, n_results);
        $display("Run: table lookups, held capitals, space runs, bad UTF-8, stalls both sides");
        if (n_errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
`default_nettype wire
